// ===== rtl/chunked_silence_region_detector_macros.svh =====
// Assertion macros for the chunked silence region detector.
// Used by the RTL files that carry concurrent assertions; no dependencies.
`ifndef CHUNKED_SILENCE_REGION_DETECTOR_MACROS_SVH
`define CHUNKED_SILENCE_REGION_DETECTOR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSRD_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSRD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/csrd_pkg.sv =====
// Shared types and constants for the chunked silence region detector.
// No dependencies; used by csrd_close and the top level.
`default_nettype none

package csrd_pkg;

    // Register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_FRAMES   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_FRAMES     = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAD_FRAMES     = 2'd3;

    // Register reset values
    localparam logic [15:0] PEAK_THRESHOLD_RST = 16'd328;
    localparam logic [15:0] CHUNK_FRAMES_RST   = 16'd441;
    localparam logic [31:0] MIN_FRAMES_RST     = 32'd22050;
    localparam logic [31:0] PAD_FRAMES_RST     = 32'd11025;

    // Default region limit
    localparam int MAX_REGIONS_DEF = 256;

    // Outcome of closing a candidate region
    typedef struct packed {
        logic        accept;   // long enough and below the region limit
        logic        keep;     // accepted and still non-empty after padding
        logic [31:0] start;
        logic [31:0] stop;
    } close_t;

endpackage

`default_nettype wire

// ===== rtl/csrd_close.sv =====
// Region close unit: length test, limit test and padding of one candidate.
// Depends on csrd_pkg (close_t).
`default_nettype none

module csrd_close (
    input  wire logic [31:0]    first,
    input  wire logic [31:0]    stop,
    input  wire logic [31:0]    min_frames,
    input  wire logic [31:0]    pad_frames,
    input  wire logic           room,
    output csrd_pkg::close_t    res
);

    logic [31:0] len;
    logic [33:0] lo;

    // Length modulo 2^32, padded low end computed without overflow
    always_comb
    begin
        len        = stop - first;
        lo         = {2'b00, first} + {1'b0, pad_frames, 1'b0};
        res.accept = room && (len >= min_frames);
        res.keep   = res.accept && ((pad_frames == 32'd0) || (lo < {2'b00, stop}));
        res.start  = first + pad_frames;
        res.stop   = stop - pad_frames;
    end

endmodule

`default_nettype wire

// ===== rtl/chunked_silence_region_detector.sv =====
// Top level of the chunked silence region detector: input word register,
// per-sample chunk/silence logic, result register. Uses csrd_pkg, csrd_close.
`default_nettype none
`include "chunked_silence_region_detector_macros.svh"

//  channel  | dir | tdata                          | tuser        | tlast
//  ---------+-----+--------------------------------+--------------+------------
//  s_*      | in  | [15:0] sample                  | -            | last
//  m_*      | out | [31:0] region_start [63:32] end| region_valid | stream_done
//  cfg_*    | in  | cfg_index selects, cfg_data    | -            | -
//
// One word per cycle sustained while the result side accepts; each sample passes
// through the input register and then the result register.
// The chunk/silence state loop closes around the input register, which sets the rate.
// Reset (rst_n low, asynchronous) clears the stream state and loads the
// register defaults. A stalled result holds the input register, and s_tready
// drops only while both stages are full and m_tready is low.

module chunked_silence_region_detector #(
    parameter int MAX_REGIONS = csrd_pkg::MAX_REGIONS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // input stream
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [15:0]                    s_tdata,   // [15:0] sample
    input  wire logic                           s_tlast,   // last
    // result stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [63:0]                         m_tdata,   // [31:0] start, [63:32] end
    output logic                                m_tuser,   // [0] region_valid
    output logic                                m_tlast,   // stream_done
    // configuration
    input  wire logic                           cfg_we,
    input  wire logic [csrd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [csrd_pkg::CFG_DATA_W-1:0] cfg_data
);

    localparam int ACC_W = $clog2(MAX_REGIONS + 1);

    // configuration registers
    logic [15:0] peak_threshold_reg;
    logic [15:0] chunk_frames_reg;
    logic [31:0] min_frames_reg;
    logic [31:0] pad_frames_reg;

    // input stage
    logic        s1_valid_reg;
    logic [15:0] s1_sample_reg;
    logic        s1_last_reg;

    // stream state
    logic [31:0]      frame_index_reg,       frame_index_next;
    logic [15:0]      chunk_position_reg,    chunk_position_next;
    logic [31:0]      chunk_start_frame_reg, chunk_start_frame_next;
    logic [15:0]      chunk_peak_reg,        chunk_peak_next;
    logic             in_silence_reg,        in_silence_next;
    logic [31:0]      silence_begin_reg,     silence_begin_next;
    logic [ACC_W-1:0] accepted_regions_reg,  accepted_regions_next;

    // result stage
    logic        out_valid_reg;
    logic [31:0] out_start_reg;
    logic [31:0] out_end_reg;
    logic        out_kept_reg;
    logic        out_done_reg;

    // per-sample logic
    logic             out_free;
    logic             s1_adv;
    logic [15:0]      mag;
    logic [15:0]      peak_new;
    logic [15:0]      cf;
    logic [16:0]      pos;
    logic             chunk_end;
    logic             quiet;
    logic             close_loud;
    logic             close_last;
    logic             do_close;
    logic [31:0]      next_frame;
    logic [31:0]      close_first;
    logic [31:0]      close_stop;
    logic             room;
    logic             have;
    logic             emit;
    csrd_pkg::close_t close_res;

    // handshake
    assign out_free = !out_valid_reg || m_tready;
    assign s1_adv   = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            peak_threshold_reg <= csrd_pkg::PEAK_THRESHOLD_RST;
            chunk_frames_reg   <= csrd_pkg::CHUNK_FRAMES_RST;
            min_frames_reg     <= csrd_pkg::MIN_FRAMES_RST;
            pad_frames_reg     <= csrd_pkg::PAD_FRAMES_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                csrd_pkg::REG_PEAK_THRESHOLD: peak_threshold_reg <= cfg_data[15:0];
                csrd_pkg::REG_CHUNK_FRAMES:   chunk_frames_reg   <= cfg_data[15:0];
                csrd_pkg::REG_MIN_FRAMES:     min_frames_reg     <= cfg_data;
                csrd_pkg::REG_PAD_FRAMES:     pad_frames_reg     <= cfg_data;
                default: ;
            endcase
        end
    end

    // input word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            s1_sample_reg <= s_tdata;
            s1_last_reg   <= s_tlast;
        end
    end

    // chunk peak and end-of-chunk detection
    always_comb
    begin
        mag        = s1_sample_reg[15] ? (~s1_sample_reg + 16'd1) : s1_sample_reg;
        peak_new   = (mag > chunk_peak_reg) ? mag : chunk_peak_reg;
        cf         = (chunk_frames_reg == 16'd0) ? 16'd1 : chunk_frames_reg;
        pos        = {1'b0, chunk_position_reg} + 17'd1;
        chunk_end  = s1_last_reg || (pos >= {1'b0, cf});
        quiet      = peak_new < peak_threshold_reg;
        next_frame = frame_index_reg + 32'd1;
        room       = accepted_regions_reg < ACC_W'(MAX_REGIONS);
    end

    // a loud chunk ends a run; the final quiet chunk ends it at the stream end
    always_comb
    begin
        close_loud  = chunk_end && !quiet && in_silence_reg;
        close_last  = chunk_end && s1_last_reg && quiet;
        do_close    = close_loud || close_last;
        close_first = in_silence_reg ? silence_begin_reg : chunk_start_frame_reg;
        close_stop  = close_loud ? chunk_start_frame_reg : next_frame;
    end

    csrd_close u_close (
        .first      (close_first),
        .stop       (close_stop),
        .min_frames (min_frames_reg),
        .pad_frames (pad_frames_reg),
        .room       (room),
        .res        (close_res)
    );

    assign have = do_close && close_res.keep;
    assign emit = have || s1_last_reg;

    // next stream state
    always_comb
    begin
        frame_index_next       = next_frame;
        chunk_position_next    = pos[15:0];
        chunk_start_frame_next = chunk_start_frame_reg;
        chunk_peak_next        = peak_new;
        in_silence_next        = in_silence_reg;
        silence_begin_next     = silence_begin_reg;
        accepted_regions_next  = accepted_regions_reg;
        if (do_close && close_res.accept)
        begin
            accepted_regions_next = accepted_regions_reg + ACC_W'(1);
        end
        if (chunk_end)
        begin
            chunk_position_next    = 16'd0;
            chunk_peak_next        = 16'd0;
            chunk_start_frame_next = next_frame;
            in_silence_next        = quiet;
            if (quiet && !in_silence_reg)
            begin
                silence_begin_next = chunk_start_frame_reg;
            end
        end
        // end of stream returns everything to its reset value
        if (s1_last_reg)
        begin
            frame_index_next       = 32'd0;
            chunk_position_next    = 16'd0;
            chunk_start_frame_next = 32'd0;
            chunk_peak_next        = 16'd0;
            in_silence_next        = 1'b0;
            silence_begin_next     = 32'd0;
            accepted_regions_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_index_reg       <= 32'd0;
            chunk_position_reg    <= 16'd0;
            chunk_start_frame_reg <= 32'd0;
            chunk_peak_reg        <= 16'd0;
            in_silence_reg        <= 1'b0;
            silence_begin_reg     <= 32'd0;
            accepted_regions_reg  <= '0;
        end
        else if (s1_adv)
        begin
            frame_index_reg       <= frame_index_next;
            chunk_position_reg    <= chunk_position_next;
            chunk_start_frame_reg <= chunk_start_frame_next;
            chunk_peak_reg        <= chunk_peak_next;
            in_silence_reg        <= in_silence_next;
            silence_begin_reg     <= silence_begin_next;
            accepted_regions_reg  <= accepted_regions_next;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= emit;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_start_reg <= have ? close_res.start : 32'd0;
            out_end_reg   <= have ? close_res.stop  : 32'd0;
            out_kept_reg  <= have;
            out_done_reg  <= s1_last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_end_reg, out_start_reg};
    assign m_tuser  = out_kept_reg;
    assign m_tlast  = out_done_reg;

    // checks
    `CSRD_ASSERT_SAME(a_acc_limit, clk, rst_n, 1'b1,
        accepted_regions_reg <= ACC_W'(MAX_REGIONS), "region count above limit")
    `CSRD_ASSERT_NEXT(a_end_clears, clk, rst_n, s1_adv && s1_last_reg,
        frame_index_reg == 32'd0 && !in_silence_reg && accepted_regions_reg == '0,
        "stream state not cleared after final sample")
    `CSRD_ASSERT_SAME(a_mid_result_kept, clk, rst_n, out_valid_reg && !out_done_reg,
        out_kept_reg, "non-final result without a kept region")

endmodule

`default_nettype wire

// ===== verif/chunked_silence_region_detector_tb.sv =====
// Self-checking testbench for chunked_silence_region_detector: a directed table,
// then shaped random streams checked against an in-bench silence tracker.
// Depends on csrd_pkg and the RTL top level only.
`timescale 1ns / 1ps

module chunked_silence_region_detector_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 300;
    localparam int ITEM_TARGET  = 1250;
    localparam int LIMIT_WORDS  = 560;
    localparam int LIMIT_CYCLES = 1000000;
    localparam int SCRIPT_LEN   = 36;

    // One result word: padded region bounds plus flags
    typedef struct packed {
        logic [31:0] first;
        logic [31:0] stop;
        logic        kept;
        logic        done;
    } region_t;

    // Directed table row: either a register write or one sample word
    typedef struct packed {
        logic                           is_cfg;
        logic [csrd_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                    value;
        logic                           lst;
        logic                           typed;
        region_t                        want;
    } step_row_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [15:0]                     s_tdata = '0;
    logic                            s_tlast = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [63:0]                     m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;
    logic                            cfg_we = 1'b0;
    logic [csrd_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [csrd_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // Tracker copy of the registers
    logic [15:0] thr_reg;
    logic [15:0] chunk_len;
    logic [31:0] min_len;
    logic [31:0] pad_len;

    // Tracker copy of the stream state
    logic [31:0] frame_idx;
    logic [15:0] chunk_pos;
    logic [31:0] chunk_base;
    logic [16:0] chunk_peak;
    logic        in_quiet;
    logic [31:0] quiet_from;
    int          regions_taken;

    region_t   pending_regions[$];
    step_row_t script [SCRIPT_LEN];

    int n_errors = 0;
    int n_samples = 0;
    int n_streams = 0;
    int n_results = 0;
    int n_kept = 0;
    int n_cfg = 0;
    bit gapless = 1'b0;
    bit hold_armed = 1'b0;
    bit long_hold_done = 1'b0;

    chunked_silence_region_detector #(
        .MAX_REGIONS(csrd_pkg::MAX_REGIONS_DEF)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // [15:0] sample
        .s_tlast  (s_tlast),   // last
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),   // [31:0] region_start, [63:32] region_end
        .m_tuser  (m_tuser),   // [0] region_valid
        .m_tlast  (m_tlast),   // stream_done
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    task automatic flag_mismatch(input string msg);
        $display("%0t ERROR: %s", $time, msg);
        n_errors++;
    endtask

    task automatic clear_tracker();
        frame_idx     = '0;
        chunk_pos     = '0;
        chunk_base    = '0;
        chunk_peak    = '0;
        in_quiet      = 1'b0;
        quiet_from    = '0;
        regions_taken = 0;
    endtask

    // Length and limit test on a closed quiet run, then trim by the pad
    task automatic close_span(input logic [31:0] first, input logic [31:0] stop,
                              output logic kept, output logic [31:0] rs,
                              output logic [31:0] re);
        logic [31:0] span;
        logic [63:0] reach;
        kept = 1'b0;
        rs   = '0;
        re   = '0;
        span = stop - first;
        if (span >= min_len && regions_taken < csrd_pkg::MAX_REGIONS_DEF)
        begin
            regions_taken++;
            reach = {32'd0, first} + {31'd0, pad_len, 1'b0};
            if (pad_len == 0)
            begin
                kept = 1'b1;
                rs   = first;
                re   = stop;
            end
            else if (reach < {32'd0, stop})
            begin
                kept = 1'b1;
                rs   = first + pad_len;
                re   = stop - pad_len;
            end
        end
    endtask

    // Per-sample update of the silence tracker; hit says a word is due
    task automatic advance_silence_tracker(input logic [15:0] smp, input logic lst,
                                           output bit hit, output region_t res);
        logic [16:0] mag;
        logic [16:0] pos;
        logic [15:0] eff_len;
        logic [31:0] nxt;
        logic [31:0] rs;
        logic [31:0] re;
        logic        kept;
        mag     = smp[15] ? (17'h10000 - {1'b0, smp}) : {1'b0, smp};
        eff_len = (chunk_len == 0) ? 16'd1 : chunk_len;
        pos     = {1'b0, chunk_pos} + 17'd1;
        nxt     = frame_idx + 32'd1;
        kept    = 1'b0;
        rs      = '0;
        re      = '0;
        if (mag > chunk_peak)
            chunk_peak = mag;
        if (lst || pos >= {1'b0, eff_len})
        begin
            // chunk closes: quiet chunks open a run, a loud one ends it
            if (chunk_peak < {1'b0, thr_reg})
            begin
                if (!in_quiet)
                begin
                    quiet_from = chunk_base;
                    in_quiet   = 1'b1;
                end
            end
            else if (in_quiet)
            begin
                close_span(quiet_from, chunk_base, kept, rs, re);
                in_quiet = 1'b0;
            end
            // trailing run ends at the total frame count
            if (lst && in_quiet)
            begin
                close_span(quiet_from, nxt, kept, rs, re);
                in_quiet = 1'b0;
            end
            chunk_pos  = '0;
            chunk_peak = '0;
            chunk_base = nxt;
        end
        else
            chunk_pos = pos[15:0];
        frame_idx = nxt;
        hit       = kept || lst;
        res.first = kept ? rs : 32'd0;
        res.stop  = kept ? re : 32'd0;
        res.kept  = kept;
        res.done  = lst;
        if (kept)
            n_kept++;
        if (lst)
            clear_tracker();
    endtask

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (gapless || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // Sample with magnitude below the current threshold, or zero when the threshold is zero
    function automatic logic [15:0] quiet_sample();
        int unsigned m;
        if (thr_reg == 0)
            return 16'd0;
        m = $urandom_range(0, 32'(thr_reg) - 1);
        return $urandom_range(0, 1) ? 16'(0 - m) : 16'(m);
    endfunction

    // Sample that usually reaches the threshold
    function automatic logic [15:0] loud_sample();
        int unsigned m;
        if ($urandom_range(0, 1))
            return 16'($urandom);
        if (thr_reg > 16'd32767)
            return 16'h8000;
        m = $urandom_range(32'(thr_reg), 32767);
        return $urandom_range(0, 1) ? 16'(0 - m) : 16'(m);
    endfunction

    function automatic step_row_t smp_row(input logic [15:0] v, input logic lst);
        step_row_t row;
        row       = '0;
        row.value = {16'd0, v};
        row.lst   = lst;
        return row;
    endfunction

    function automatic step_row_t cfg_row(input logic [csrd_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [31:0] v);
        step_row_t row;
        row        = '0;
        row.is_cfg = 1'b1;
        row.idx    = idx;
        row.value  = v;
        return row;
    endfunction

    function automatic step_row_t chk_row(input logic [15:0] v, input logic lst,
                                          input logic [31:0] rs, input logic [31:0] re,
                                          input logic kept, input logic done);
        step_row_t row;
        row       = smp_row(v, lst);
        row.typed = 1'b1;
        row.want  = '{first: rs, stop: re, kept: kept, done: done};
        return row;
    endfunction

    // Lower valid, wait for every expected word, then let the pipe empty
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_regions.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [csrd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] val);
        settle_block();
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            csrd_pkg::REG_PEAK_THRESHOLD: thr_reg   = val[15:0];
            csrd_pkg::REG_CHUNK_FRAMES:   chunk_len = val[15:0];
            csrd_pkg::REG_MIN_FRAMES:     min_len   = val;
            csrd_pkg::REG_PAD_FRAMES:     pad_len   = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic offer_sample(input logic [15:0] smp, input logic lst,
                                input logic typed, input region_t want);
        int      gap;
        bit      hit;
        region_t got;
        gap = gap_len();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= smp;
        s_tlast  <= lst;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        advance_silence_tracker(smp, lst, hit, got);
        if (typed)
            pending_regions.push_back(want);
        else if (hit)
            pending_regions.push_back(got);
        n_samples++;
        if (lst)
            n_streams++;
    endtask

    // Register set for one random stream; the first two are the extremes
    task automatic pick_config(input int phase);
        logic [31:0] thr;
        logic [31:0] chk;
        logic [31:0] mn;
        logic [31:0] pd;
        int          r;
        if (phase == 0)
        begin
            thr = 32'd0;
            chk = 32'd65535;
            mn  = 32'hFFFF_FFFF;
            pd  = 32'hFFFF_FFFF;
        end
        else if (phase == 1)
        begin
            thr = 32'd32768;
            chk = 32'd0;
            mn  = 32'd0;
            pd  = 32'd0;
        end
        else
        begin
            r   = $urandom_range(0, 99);
            thr = (r < 8) ? 32'd0 : (r < 16) ? 32'd32768 :
                  (r < 70) ? 32'($urandom_range(1, 2000)) : 32'($urandom_range(1, 32768));
            r   = $urandom_range(0, 99);
            chk = (r < 8) ? 32'd0 : (r < 12) ? 32'd65535 : 32'($urandom_range(1, 8));
            r   = $urandom_range(0, 99);
            mn  = (r < 10) ? 32'd0 : (r < 14) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 24));
            r   = $urandom_range(0, 99);
            pd  = (r < 15) ? 32'd0 : (r < 19) ? 32'hFFFF_FFFF : 32'($urandom_range(0, 3));
            // junk above the 16-bit registers must be ignored
            if ($urandom_range(0, 3) == 0)
                thr[31:16] = 16'($urandom);
            if ($urandom_range(0, 3) == 0)
                chk[31:16] = 16'($urandom);
        end
        write_reg(csrd_pkg::REG_PEAK_THRESHOLD, thr);
        write_reg(csrd_pkg::REG_CHUNK_FRAMES, chk);
        write_reg(csrd_pkg::REG_MIN_FRAMES, mn);
        write_reg(csrd_pkg::REG_PAD_FRAMES, pd);
    endtask

    // Quiet and loud segments a few chunks long, or plain noise
    task automatic run_stream(input int len, input bit noise);
        int          seg_left;
        int          eff;
        int          retune_at;
        bit          quiet;
        logic [15:0] v;
        seg_left  = 0;
        quiet     = 1'b0;
        retune_at = (len > 1 && $urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : -1;
        gapless   = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
        begin
            // chunk size changed in the middle of a stream
            if (i == retune_at)
                write_reg(csrd_pkg::REG_CHUNK_FRAMES, 32'($urandom_range(1, 6)));
            if (seg_left == 0)
            begin
                eff      = (chunk_len == 0) ? 1 : (chunk_len > 16) ? 16 : int'(chunk_len);
                seg_left = eff * $urandom_range(1, 4);
                quiet    = $urandom_range(0, 1);
            end
            seg_left--;
            v = noise ? 16'($urandom) : (quiet ? quiet_sample() : loud_sample());
            offer_sample(v, i == len - 1, 1'b0, '0);
        end
        gapless = 1'b0;
    endtask

    // Alternating quiet and loud single-sample chunks, enough to pass the region limit
    task automatic run_limit_stream();
        logic [15:0] v;
        write_reg(csrd_pkg::REG_PEAK_THRESHOLD, 32'd100);
        write_reg(csrd_pkg::REG_CHUNK_FRAMES, 32'd1);
        write_reg(csrd_pkg::REG_MIN_FRAMES, 32'd0);
        write_reg(csrd_pkg::REG_PAD_FRAMES, 32'd0);
        for (int i = 0; i < LIMIT_WORDS; i++)
        begin
            if (i == 20)
                hold_armed = 1'b1;
            v = i[0] ? loud_sample() : 16'($urandom_range(0, 99));
            offer_sample(v, i == LIMIT_WORDS - 1, 1'b0, '0);
        end
    endtask

    task automatic check_region();
        region_t want;
        n_results++;
        if (pending_regions.size() == 0)
            flag_mismatch($sformatf("unexpected word start=%h end=%h valid=%b done=%b",
                                    m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast));
        else
        begin
            want = pending_regions.pop_front();
            if (m_tdata[31:0] !== want.first || m_tdata[63:32] !== want.stop ||
                m_tuser !== want.kept || m_tlast !== want.done)
                flag_mismatch($sformatf(
                    "word %0d: got %h/%h v%b d%b, want %h/%h v%b d%b", n_results,
                    m_tdata[31:0], m_tdata[63:32], m_tuser, m_tlast,
                    want.first, want.stop, want.kept, want.done));
        end
    endtask

    // Result side: check every accepted word, stall at random
    initial
    begin : result_side
        int hold_cnt;
        int r;
        hold_cnt = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                check_region();
            if (hold_armed && !long_hold_done && m_tvalid)
            begin
                // long hold-off so the block backs up into its input
                m_tready       <= 1'b0;
                hold_cnt       = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            else if (hold_cnt > 0)
                hold_cnt--;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 8)
                begin
                    m_tready <= 1'b1;
                    hold_cnt = $urandom_range(40, 200);
                end
                else if (r < 65)
                begin
                    m_tready <= 1'b1;
                    hold_cnt = $urandom_range(0, 11);
                end
                else
                begin
                    m_tready <= 1'b0;
                    hold_cnt = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 40)
                                                           : $urandom_range(0, 2);
                end
            end
        end
    end

    // Stimulus side
    initial
    begin : stimulus_side
        int phase;
        thr_reg   = csrd_pkg::PEAK_THRESHOLD_RST;
        chunk_len = csrd_pkg::CHUNK_FRAMES_RST;
        min_len   = csrd_pkg::MIN_FRAMES_RST;
        pad_len   = csrd_pkg::PAD_FRAMES_RST;
        clear_tracker();
        script = '{
            // after reset: one quiet sample, far too short for the default minimum
            chk_row(16'h0000, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
            cfg_row(csrd_pkg::REG_PEAK_THRESHOLD, 32'd100),
            cfg_row(csrd_pkg::REG_CHUNK_FRAMES, 32'd2),
            cfg_row(csrd_pkg::REG_MIN_FRAMES, 32'd4),
            cfg_row(csrd_pkg::REG_PAD_FRAMES, 32'd0),
            // two quiet chunks, peak just below threshold, then a loud one
            smp_row(16'h0000, 1'b0),
            smp_row(16'h0005, 1'b0),
            smp_row(16'h0063, 1'b0),
            smp_row(16'hFF9D, 1'b0),
            smp_row(16'h0064, 1'b0),
            chk_row(16'h0000, 1'b0, 32'd0, 32'd4, 1'b1, 1'b0),
            smp_row(16'h8000, 1'b0),
            smp_row(16'h7FFF, 1'b0),
            // short trailing run at the end of the stream is rejected
            chk_row(16'h0000, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1),
            cfg_row(csrd_pkg::REG_PAD_FRAMES, 32'd1),
            cfg_row(csrd_pkg::REG_MIN_FRAMES, 32'd0),
            // first region vanishes under padding, second survives
            smp_row(16'h0000, 1'b0),
            smp_row(16'h0000, 1'b0),
            smp_row(16'h7FFF, 1'b0),
            smp_row(16'h0001, 1'b0),
            smp_row(16'h0000, 1'b0),
            smp_row(16'h0000, 1'b0),
            smp_row(16'h0000, 1'b0),
            smp_row(16'h0000, 1'b0),
            chk_row(16'h8000, 1'b1, 32'd5, 32'd7, 1'b1, 1'b1),
            // full-scale threshold, chunk size zero, padding near overflow
            cfg_row(csrd_pkg::REG_PEAK_THRESHOLD, 32'd32768),
            cfg_row(csrd_pkg::REG_CHUNK_FRAMES, 32'd0),
            cfg_row(csrd_pkg::REG_PAD_FRAMES, 32'hFFFF_FFFF),
            smp_row(16'h8000, 1'b0),
            smp_row(16'h7FFF, 1'b0),
            cfg_row(csrd_pkg::REG_CHUNK_FRAMES, 32'd4),
            smp_row(16'h0000, 1'b0),
            smp_row(16'h0000, 1'b0),
            // shrink the chunk below the samples already taken
            cfg_row(csrd_pkg::REG_CHUNK_FRAMES, 32'd2),
            smp_row(16'h0000, 1'b0),
            chk_row(16'h8000, 1'b1, 32'd0, 32'd0, 1'b0, 1'b1)
        };

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table
        for (int i = 0; i < SCRIPT_LEN; i++)
        begin
            if (script[i].is_cfg)
                write_reg(script[i].idx, script[i].value);
            else
                offer_sample(script[i].value[15:0], script[i].lst, script[i].typed,
                             script[i].want);
        end

        // random streams, with one long stream that reaches the region limit
        phase = 0;
        while (n_samples < ITEM_TARGET)
        begin
            if (phase == 3)
                run_limit_stream();
            else
            begin
                pick_config(phase);
                run_stream(($urandom_range(0, 9) == 0) ? $urandom_range(1, 3)
                                                       : $urandom_range(20, 90),
                           $urandom_range(0, 5) == 0);
            end
            phase++;
        end

        settle_block();
        $display("covered %0d samples in %0d streams with %0d register writes",
                 n_samples, n_streams, n_cfg);
        $display("checked %0d result words, %0d regions kept, long output stall %0s",
                 n_results, n_kept, long_hold_done ? "applied" : "not applied");
        if (n_errors == 0)
            $display("chunked_silence_region_detector_tb: done, clean");
        else
            $display("chunked_silence_region_detector_tb: done, errors");
        $finish;
    end

    // Watchdog
    initial
    begin
        #(64'(LIMIT_CYCLES) * CLK_PERIOD);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("chunked_silence_region_detector_tb: done, errors");
        $finish;
    end

endmodule
